@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that carry checks.
// Relies on the clock and reset names used throughout the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_CHK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ppt_pkg.sv @@
// Types and constants for the playback position tracker.
// No dependencies; imported by the interfaces and all modules.
package ppt_pkg;

   localparam int POS_W      = 32;
   localparam int LEN_W      = 32;
   localparam int SPD_W      = 16;
   localparam int ELAP_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int NP_W       = 34;   // signed new position, full precision
   localparam int DVD_W      = 33;   // magnitude of a wrapped position
   localparam int PROD_W     = ELAP_W + SPD_W;
   localparam int FRAC_BITS  = 8;
   localparam int MUL_STEPS  = 16;
   localparam int MUL_CNT_W  = 4;

   localparam logic [SPD_W-1:0] SPEED_RESET = 16'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP   = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PLAY  = 2'd1,
      CMD_PAUSE = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PS_STOPPED = 2'd0,
      PS_PLAYING = 2'd1,
      PS_PAUSED  = 2'd2
   } play_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_FIN
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_sts_type;

endpackage

@@ rtl/ppt_if.sv @@
// Valid/ready channel interfaces: command items, result items, register writes.
// Depends on ppt_pkg for field widths.
interface ppt_req_if import ppt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [ELAP_W-1:0] elapsed_ms;
   modport source (output valid, command, elapsed_ms, input ready);
   modport sink   (input valid, command, elapsed_ms, output ready);
endinterface

interface ppt_rsp_if import ppt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position_ms;
   logic [1:0]       play_state;
   logic             update_strobe;
   modport source (output valid, position_ms, play_state, update_strobe, input ready);
   modport sink   (input valid, position_ms, play_state, update_strobe, output ready);
endinterface

interface ppt_csr_if import ppt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/playback_position_tracker.sv @@
// Playback position tracker: play state, position advance, wrap or clamp.
// Depends on ppt_pkg, ppt_if (channels), ppt_rem_unit and assert_macros.svh.
//
//   channel  direction  payload                                  handshake
//   req_if   in         command, elapsed_ms                      valid/ready
//   rsp_if   out        position_ms, play_state, update_strobe   valid/ready
//   csr_if   in         index, data (length, speed, loop)        valid/ready
//
// Sequence: one item at a time. Play, pause, stop and idle ticks pass IDLE and
// FIN; a playing tick adds a shift-add multiply (MUL) and an add (ADD), a wrap
// also a pass through the bit-serial remainder unit (DIV).
// Reset: synchronous; length 0, speed 1.0, loop off, position 0, stopped.
// Stalls: the result sits in an output register; the next item is accepted
// while it waits, and a finished item holds in FIN until that register frees.
`include "assert_macros.svh"
module playback_position_tracker import ppt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppt_req_if.sink   req_if,
   ppt_rsp_if.source rsp_if,
   ppt_csr_if.sink   csr_if
);

   // configuration
   logic [LEN_W-1:0]        len_ff;
   logic signed [SPD_W-1:0] speed_ff;
   logic                    loop_ff;

   // sequencer
   seq_state_type state_ff, state_in;
   logic req_ready, mul_step, add_step, div_start, div_done, rsp_load;

   // block state
   logic [POS_W-1:0] pos_ff;
   play_type         run_state_ff;

   // per-item working registers
   logic                 strobe_ff;
   logic [PROD_W-1:0]    mul_p_ff;      // {partial sum, remaining multiplier bits}
   logic [SPD_W-1:0]     mcand_ff;      // speed magnitude
   logic                 neg_ff;        // speed sign
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 wrap_neg_ff;   // wrap of a position below zero

   // output register
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic [1:0]       rsp_state_ff;
   logic             rsp_strobe_ff;

   // datapath
   logic                 req_fire;
   cmd_type              cmd;
   logic                 tick_live;
   logic                 tick_run;
   logic [SPD_W-1:0]     speed_mag;
   logic [SPD_W:0]       mul_sum;
   logic [NP_W-1:0]      delta;
   logic [NP_W-1:0]      np_sum;
   logic [NP_W-1:0]      np_negated;
   logic                 np_neg;
   logic                 np_over;
   logic                 need_div;
   logic [DVD_W-1:0]     div_dividend;
   logic [LEN_W-1:0]     rem;
   logic [POS_W-1:0]     wrap_pos;
   rem_sts_type          rem_sts;

   assign req_fire  = req_if.valid && req_ready;
   assign cmd       = cmd_type'(req_if.command);
   assign tick_live = (run_state_ff != PS_STOPPED) && (len_ff != '0);
   assign tick_run  = (cmd == CMD_TICK) && tick_live && (run_state_ff == PS_PLAYING);
   assign speed_mag = speed_ff[SPD_W-1] ? SPD_W'(-speed_ff) : speed_ff;

   // one multiplier bit per cycle, LSB first
   assign mul_sum = {1'b0, mul_p_ff[PROD_W-1:ELAP_W]}
                  + {1'b0, (mul_p_ff[0] ? mcand_ff : {SPD_W{1'b0}})};

   // magnitude truncation gives rounding toward zero
   always_comb begin
      delta      = {{(NP_W - PROD_W + FRAC_BITS){1'b0}}, mul_p_ff[PROD_W-1:FRAC_BITS]};
      if (neg_ff) delta = NP_W'(0) - delta;
      np_sum     = {{(NP_W - POS_W){1'b0}}, pos_ff} + delta;
      np_negated = NP_W'(0) - np_sum;
      np_neg     = np_sum[NP_W-1];
      np_over    = !np_neg && (np_sum[DVD_W-1:0] >= {1'b0, len_ff});
      need_div   = loop_ff && (np_neg || np_over);
      div_dividend = np_neg ? np_negated[DVD_W-1:0] : np_sum[DVD_W-1:0];
   end

   // below zero: len - r, or zero when r is zero
   assign wrap_pos = !wrap_neg_ff ? rem : ((rem == '0) ? '0 : len_ff - rem);

   ppt_rem_unit #(
      .DVD_W_P (DVD_W),
      .DVS_W_P (LEN_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (len_ff),
      .sts       (rem_sts),
      .remainder (rem)
   );

   // configuration writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         speed_ff <= SPEED_RESET;
         loop_ff  <= 1'b0;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_LENGTH: len_ff   <= csr_if.data[LEN_W-1:0];
            CSR_SPEED:  speed_ff <= csr_if.data[SPD_W-1:0];
            CSR_LOOP:   loop_ff  <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = tick_run ? ST_MUL : ST_FIN;
         ST_MUL:  if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) state_in = ST_ADD;
         ST_ADD:  state_in = need_div ? ST_DIV : ST_FIN;
         ST_DIV:  if (rem_sts.done) state_in = ST_FIN;
         ST_FIN:  if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mul_step  = 1'b0;
      add_step  = 1'b0;
      div_start = 1'b0;
      div_done  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL:  mul_step  = 1'b1;
         ST_ADD: begin
            add_step  = 1'b1;
            div_start = need_div;
         end
         ST_DIV:  div_done = rem_sts.done;
         ST_FIN:  rsp_load = !rsp_valid_ff || rsp_if.ready;
         default: ;
      endcase
   end

   assign req_if.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // block state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_state_ff <= PS_STOPPED;
         cnt_ff       <= '0;
      end else begin
         if (req_fire) begin
            unique case (cmd)
               CMD_TICK: begin
                  strobe_ff <= tick_live;
                  mul_p_ff  <= {{SPD_W{1'b0}}, req_if.elapsed_ms};
                  mcand_ff  <= speed_mag;
                  neg_ff    <= speed_ff[SPD_W-1];
                  cnt_ff    <= '0;
               end
               CMD_PLAY: begin
                  strobe_ff    <= 1'b0;
                  run_state_ff <= PS_PLAYING;
               end
               CMD_PAUSE: begin
                  strobe_ff <= 1'b0;
                  if (run_state_ff == PS_PLAYING) run_state_ff <= PS_PAUSED;
               end
               CMD_STOP: begin
                  strobe_ff    <= 1'b0;
                  run_state_ff <= PS_STOPPED;
                  pos_ff       <= '0;
               end
               default: ;
            endcase
         end
         if (mul_step) begin
            mul_p_ff <= {mul_sum, mul_p_ff[ELAP_W-1:1]};
            cnt_ff   <= cnt_ff + 1'b1;
         end
         if (add_step) begin
            wrap_neg_ff <= np_neg;
            if (!need_div) begin
               priority if (np_neg) begin
                  pos_ff       <= '0;
                  run_state_ff <= PS_PAUSED;
               end else if (np_over) begin
                  pos_ff       <= len_ff;
                  run_state_ff <= PS_PAUSED;
               end else begin
                  pos_ff <= np_sum[POS_W-1:0];
               end
            end
         end
         if (div_done) pos_ff <= wrap_pos;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pos_ff    <= pos_ff;
         rsp_state_ff  <= run_state_ff;
         rsp_strobe_ff <= strobe_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.position_ms   = rsp_pos_ff;
   assign rsp_if.play_state    = rsp_state_ff;
   assign rsp_if.update_strobe = rsp_strobe_ff;

   `ASSERT_CHK(a_div_tracked, (state_ff == ST_DIV) |-> (rem_sts.busy || rem_sts.done),
               "DIV state without active remainder unit")
   `ASSERT_CHK(a_mul_playing, (state_ff == ST_MUL) |-> (run_state_ff == PS_PLAYING),
               "multiply while not playing")
   `ASSERT_CHK(a_rsp_from_fin, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN),
               "result loaded outside FIN")
   `ASSERT_CHK(a_stop_zero, (rsp_valid_ff && rsp_state_ff == PS_STOPPED) |-> (rsp_pos_ff == '0),
               "stopped with nonzero position")

endmodule

@@ rtl/ppt_rem_unit.sv @@
// Restoring remainder unit, one dividend bit per cycle.
// Depends on ppt_pkg (status struct) and assert_macros.svh.
`include "assert_macros.svh"
module ppt_rem_unit import ppt_pkg::*; #(
   parameter int DVD_W_P = 33,
   parameter int DVS_W_P = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W_P-1:0] dividend,
   input  logic [DVS_W_P-1:0] divisor,
   output rem_sts_type        sts,
   output logic [DVS_W_P-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W_P);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DVD_W_P-1:0] dvd_ff;
   logic [DVS_W_P-1:0] dvs_ff;
   logic [DVS_W_P-1:0] rem_ff;
   logic [DVS_W_P-1:0] rem_in;
   logic [DVS_W_P:0]   trial;
   logic [DVS_W_P:0]   diff;

   // shift next dividend bit in, subtract when it fits
   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W_P-1]};
      diff   = trial - {1'b0, dvs_ff};
      rem_in = (trial >= {1'b0, dvs_ff}) ? diff[DVS_W_P-1:0] : trial[DVS_W_P-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W_P - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W_P-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

   `ASSERT_CHK(a_start_idle, start |-> !busy_ff, "remainder unit restarted while busy")
   `ASSERT_CHK(a_rem_range, (done_ff && dvs_ff != '0) |-> (rem_ff < dvs_ff), "remainder out of range")
   `ASSERT_NEXT(a_done_pulse, done_ff, !done_ff && !busy_ff, "done held past one cycle")

endmodule

@@ dv/ppt_position_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the playback position tracker: watches the three channels,
// predicts each result from its own copy of the settings and play state.
// Depends on ppt_pkg for widths, command codes and play states.
module ppt_position_checker import ppt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [ELAP_W-1:0]     req_elapsed_ms,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [POS_W-1:0]      rsp_position_ms,
   input  logic [1:0]            rsp_play_state,
   input  logic                  rsp_update_strobe,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count
);

   typedef struct {
      logic [POS_W-1:0] position;
      play_type         state;
      logic             strobe;
   } tracker_result_type;

   tracker_result_type pending_results [$];

   // shadow settings and play state
   logic [LEN_W-1:0]        len_ms;
   logic signed [SPD_W-1:0] speed;
   logic                    loop_on;
   logic [POS_W-1:0]        pos_ms;
   play_type                run_st;

   function automatic tracker_result_type advance_tracker(cmd_type cmd,
                                                          logic [ELAP_W-1:0] elapsed);
      tracker_result_type r;
      longint np;
      longint len;
      r.strobe = 1'b0;
      len = longint'(len_ms);
      case (cmd)
         CMD_TICK: begin
            if (run_st != PS_STOPPED && len_ms != '0) begin
               if (run_st == PS_PLAYING) begin
                  // exact product, truncated toward zero by the signed divide
                  np = longint'(pos_ms) + (longint'(elapsed) * longint'(speed)) / 256;
                  if (np >= len) begin
                     if (loop_on) begin
                        np = np % len;
                     end else begin
                        run_st = PS_PAUSED;
                        np = len;
                     end
                  end else if (np < 0) begin
                     if (loop_on) begin
                        np = np % len;
                        if (np < 0) np += len;
                     end else begin
                        run_st = PS_PAUSED;
                        np = 0;
                     end
                  end
                  pos_ms = np[POS_W-1:0];
               end
               r.strobe = 1'b1;
            end
         end
         CMD_PLAY: begin
            run_st = PS_PLAYING;
         end
         CMD_PAUSE: begin
            if (run_st == PS_PLAYING) run_st = PS_PAUSED;
         end
         default: begin
            if (run_st != PS_STOPPED) begin
               run_st = PS_STOPPED;
               pos_ms = '0;
            end
         end
      endcase
      r.position = pos_ms;
      r.state    = run_st;
      return r;
   endfunction

   always @(posedge clock) begin
      tracker_result_type want;
      if (reset) begin
         len_ms         = '0;
         speed          = SPEED_RESET;
         loop_on        = 1'b0;
         pos_ms         = '0;
         run_st         = PS_STOPPED;
         mismatch_count = 0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LENGTH: len_ms = csr_data[LEN_W-1:0];
               CSR_SPEED:  speed = csr_data[SPD_W-1:0];
               CSR_LOOP:   loop_on = csr_data[0];
               default: ;
            endcase
         end
         // results before new items: a result never belongs to an item taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual pos %0d state %0d %0b",
                        $time, rsp_position_ms, rsp_play_state, rsp_update_strobe);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_position_ms !== want.position) begin
                  $display("%0t: position_ms expected %0d actual %0d",
                           $time, want.position, rsp_position_ms);
                  mismatch_count++;
               end
               if (rsp_play_state !== want.state) begin
                  $display("%0t: play_state expected %0d actual %0d",
                           $time, want.state, rsp_play_state);
                  mismatch_count++;
               end
               if (rsp_update_strobe !== want.strobe) begin
                  $display("%0t: update_strobe expected %0b actual %0b",
                           $time, want.strobe, rsp_update_strobe);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(advance_tracker(cmd_type'(req_command), req_elapsed_ms));
      end
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the playback position tracker testbench: clock, reset, command and register stimulus.
// Depends on ppt_pkg, the channel interfaces, the tracker and ppt_position_checker.
module testbench import ppt_pkg::*; ();

   localparam int ITEM_TARGET     = 1250;
   localparam int RSP_HOLD_CYCLES = 400;   // long receiver stall, fills the block
   localparam int SETTLE_CYCLES   = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   items_accepted   = 0;
   int   results_accepted = 0;
   bit   steady_flow      = 1'b0;   // no random gaps on either side
   bit   hold_results     = 1'b0;   // ask the receiver for one long stall

   ppt_req_if req_ch ();
   ppt_rsp_if rsp_ch ();
   ppt_csr_if csr_ch ();

   playback_position_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   ppt_position_checker u_tracker_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_command       (req_ch.command),
      .req_elapsed_ms    (req_ch.elapsed_ms),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_position_ms   (rsp_ch.position_ms),
      .rsp_play_state    (rsp_ch.play_state),
      .rsp_update_strobe (rsp_ch.update_strobe),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .mismatch_count    (mismatches)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one result per item, so items_accepted - results_accepted is what is in flight
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) results_accepted <= results_accepted + 1;
   end

   // Sender: optional idle gap, then hold the item until the block takes it.
   // valid is only lowered when a gap follows, so a back-to-back item never
   // sees a low and a high assignment in the same step.
   task automatic issue_command(cmd_type cmd, logic [ELAP_W-1:0] elapsed);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.elapsed_ms <= elapsed;
      do @(posedge clock); while (!req_ch.ready);
      items_accepted++;
   endtask

   // Sender pause: stop offering and wait for every outstanding result.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (results_accepted != items_accepted) @(posedge clock);
   endtask

   // Register writes only once the block is idle; all three go back to back.
   task automatic load_settings(logic [LEN_W-1:0] len, logic [SPD_W-1:0] speed,
                                logic loop_on);
      logic [CSR_IDX_W-1:0]  reg_idx  [3];
      logic [CSR_DATA_W-1:0] reg_data [3];
      reg_idx[0]  = CSR_LENGTH;
      reg_idx[1]  = CSR_SPEED;
      reg_idx[2]  = CSR_LOOP;
      reg_data[0] = len;
      reg_data[1] = {{(CSR_DATA_W-SPD_W){speed[SPD_W-1]}}, speed};
      reg_data[2] = {{(CSR_DATA_W-1){1'b0}}, loop_on};
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= reg_idx[i];
         csr_ch.data  <= reg_data[i];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Receiver: an optional random stall before each result, or one long stall on
   // request, counted here while the sender keeps offering items.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            gap = steady_flow ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                phase_len;
      int                phase_idx;
      int                sel;
      cmd_type           cmd;
      logic [ELAP_W-1:0] elapsed;
      logic [LEN_W-1:0]  len;
      logic [SPD_W-1:0]  speed;
      logic              loop_on;

      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_TICK;
      req_ch.elapsed_ms <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= CSR_LENGTH;
      csr_ch.data       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // clamp mode, normal speed
      load_settings(32'd1000, 16'd256, 1'b0);
      issue_command(CMD_TICK, 16'd50);      // stopped: no strobe, no move
      issue_command(CMD_PAUSE, 16'd0);      // pause while stopped does nothing
      issue_command(CMD_STOP, 16'd0);       // stop while stopped does nothing
      issue_command(CMD_PLAY, 16'd0);
      issue_command(CMD_TICK, 16'd100);
      issue_command(CMD_TICK, 16'd0);       // zero advance still strobes
      issue_command(CMD_PAUSE, 16'd0);
      issue_command(CMD_TICK, 16'd500);     // paused: strobe, position held
      issue_command(CMD_PLAY, 16'd0);
      issue_command(CMD_TICK, 16'hFFFF);    // past the end: clamp to length, pause
      issue_command(CMD_PLAY, 16'd0);
      issue_command(CMD_TICK, 16'd0);       // sitting at length counts as overrun
      issue_command(CMD_STOP, 16'd0);
      // most negative speed, widest length, wrap below zero
      load_settings(32'hFFFF_FFFF, 16'h8000, 1'b1);
      issue_command(CMD_PLAY, 16'd0);
      issue_command(CMD_TICK, 16'd1);
      issue_command(CMD_TICK, 16'hFFFF);
      // fastest forward speed, wrap past the end
      load_settings(32'd700, 16'h7FFF, 1'b1);
      issue_command(CMD_TICK, 16'hFFFF);
      issue_command(CMD_TICK, 16'd1);
      // length lowered under the position: overrun even with zero advance
      load_settings(32'd5, 16'd1, 1'b1);
      issue_command(CMD_TICK, 16'd255);
      issue_command(CMD_TICK, 16'd0);
      // reverse with clamp: underrun pins to zero and pauses
      load_settings(32'd300, 16'hFF00, 1'b0);
      issue_command(CMD_PLAY, 16'd0);
      issue_command(CMD_TICK, 16'd1000);
      // zero length: playing ticks neither move nor strobe
      load_settings(32'd0, 16'd256, 1'b0);
      issue_command(CMD_PLAY, 16'd0);
      issue_command(CMD_TICK, 16'd100);
      issue_command(CMD_STOP, 16'd0);

      // --- random phases: new settings each time, state carried across ---
      phase_idx = 0;
      while (items_accepted < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:          len = '0;
            1:          len = '1;
            2, 3, 4, 5: len = $urandom_range(1, 2000);
            6, 7:       len = $urandom_range(1, 100000);
            default:    len = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0:       speed = 16'h8000;
            1:       speed = 16'h7FFF;
            2:       speed = 16'd256;
            3:       speed = '0;
            4, 5:    speed = SPD_W'($urandom_range(0, 2048) - 1024);
            default: speed = SPD_W'($urandom);
         endcase
         loop_on = 1'($urandom_range(0, 1));
         load_settings(len, speed, loop_on);

         steady_flow = ($urandom_range(0, 3) == 0);
         // first phase always gets a long output stall, later ones now and then
         if (phase_idx == 0 || $urandom_range(0, 7) == 0) hold_results = 1'b1;

         // mostly ticks, with enough play to keep the tracker moving
         phase_len = $urandom_range(40, 120);
         repeat (phase_len) begin
            sel = $urandom_range(0, 99);
            if (sel < 62)      cmd = CMD_TICK;
            else if (sel < 80) cmd = CMD_PLAY;
            else if (sel < 92) cmd = CMD_PAUSE;
            else               cmd = CMD_STOP;
            case ($urandom_range(0, 7))
               0:          elapsed = '0;
               1:          elapsed = '1;
               2, 3, 4, 5: elapsed = ELAP_W'($urandom_range(0, 300));
               default:    elapsed = ELAP_W'($urandom);
            endcase
            issue_command(cmd, elapsed);
         end
         phase_idx++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_if.sv
rtl/ppt_rem_unit.sv
rtl/playback_position_tracker.sv
dv/ppt_position_checker.sv
dv/testbench.sv
